FILE: rtl/pbd_pkg.sv
// Shared types and constants for the point-to-box distance block.
// Used by every file of the block; depends on nothing.
`timescale 1ns / 1ps

package pbd_pkg;

    localparam int COORD_BITS     = 24;
    localparam int DIST_BITS      = COORD_BITS + 1;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int RAD_BITS       = 2 * DIST_BITS;
    localparam int REGION_BITS    = 4;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BOX_LEFT   = 2'd0,
        REG_BOX_BOTTOM = 2'd1,
        REG_BOX_RIGHT  = 2'd2,
        REG_BOX_TOP    = 2'd3
    } cfg_reg_t;

    // Row and column position relative to the box.
    localparam logic [1:0] POS_LOW  = 2'd0;
    localparam logic [1:0] POS_MID  = 2'd1;
    localparam logic [1:0] POS_HIGH = 2'd2;

    localparam logic [REGION_BITS-1:0] REGION_INSIDE = 4'd4;
    localparam logic [REGION_BITS-1:0] REGION_LAST   = 4'd8;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic [REGION_BITS-1:0] region;
        logic [DIST_BITS-1:0]   near_dist;
        logic [DIST_BITS-1:0]   far_dist;
    } result_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] box_left;
        logic signed [COORD_BITS-1:0] box_bottom;
        logic signed [COORD_BITS-1:0] box_right;
        logic signed [COORD_BITS-1:0] box_top;
    } box_t;

    // Beat handed from the front end to the square-root pipeline.
    typedef struct packed {
        logic                   valid;
        logic [REGION_BITS-1:0] region;
        logic [RAD_BITS-1:0]    near_rad;
        logic [RAD_BITS-1:0]    far_rad;
    } rad_beat_t;

endpackage

FILE: rtl/pbd_front.sv
// Front end: region decision, axis gaps, squares and radicand sums (four stages).
// Depends on pbd_pkg.
`timescale 1ns / 1ps

module pbd_front
    import pbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      point_valid,
    input  point_t    point,
    input  box_t      box,
    input  logic      hold_in,
    output logic      hold_up,
    output rad_beat_t beat
);

    function automatic logic [COORD_BITS-1:0] abs_gap(input logic [COORD_BITS:0] d);
        logic [COORD_BITS:0] neg;
        neg = (~d) + 1'b1;
        return d[COORD_BITS] ? neg[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

    // Stage 1: signed differences against the four box edges.
    logic                s1_v_reg;
    logic [COORD_BITS:0] s1_dl_reg, s1_dr_reg, s1_db_reg, s1_dt_reg;
    logic [COORD_BITS:0] s1_dl_next, s1_dr_next, s1_db_next, s1_dt_next;

    // Stage 2: region and selected gaps.
    logic                   s2_v_reg;
    logic [REGION_BITS-1:0] s2_region_reg, s2_region_next;
    logic                   s2_cx_reg, s2_cy_reg, s2_cx_next, s2_cy_next;
    logic [COORD_BITS-1:0]  s2_dx_reg, s2_dy_reg, s2_fx_reg, s2_fy_reg;
    logic [COORD_BITS-1:0]  s2_dx_next, s2_dy_next, s2_fx_next, s2_fy_next;

    // Stage 3: squares.
    logic                   s3_v_reg;
    logic [REGION_BITS-1:0] s3_region_reg;
    logic [SQ_BITS-1:0]     s3_nx2_reg, s3_ny2_reg, s3_fx2_reg, s3_fy2_reg;
    logic [SQ_BITS-1:0]     s3_nx2_next, s3_ny2_next, s3_fx2_next, s3_fy2_next;

    // Stage 4: radicands.
    logic                   s4_v_reg;
    logic [REGION_BITS-1:0] s4_region_reg;
    logic [RAD_BITS-1:0]    s4_near_reg, s4_far_reg, s4_near_next, s4_far_next;

    logic hold1, hold2, hold3, hold4;

    assign hold4   = s4_v_reg & hold_in;
    assign hold3   = s3_v_reg & hold4;
    assign hold2   = s2_v_reg & hold3;
    assign hold1   = s1_v_reg & hold2;
    assign hold_up = hold1;

    assign s1_dl_next = {point.point_x[COORD_BITS-1], point.point_x}
                      - {box.box_left[COORD_BITS-1], box.box_left};
    assign s1_dr_next = {point.point_x[COORD_BITS-1], point.point_x}
                      - {box.box_right[COORD_BITS-1], box.box_right};
    assign s1_db_next = {point.point_y[COORD_BITS-1], point.point_y}
                      - {box.box_bottom[COORD_BITS-1], box.box_bottom};
    assign s1_dt_next = {point.point_y[COORD_BITS-1], point.point_y}
                      - {box.box_top[COORD_BITS-1], box.box_top};

    always_comb
    begin
        logic                  col_low, col_high, row_low, row_high;
        logic [1:0]            col_code, row_code;
        logic [COORD_BITS-1:0] al, ar, ab, at;
        // The low edge is tested first, so an inverted box still gets one column.
        col_low  = s1_dl_reg[COORD_BITS];
        col_high = !col_low && !s1_dr_reg[COORD_BITS] && (s1_dr_reg != '0);
        row_low  = s1_db_reg[COORD_BITS];
        row_high = !row_low && !s1_dt_reg[COORD_BITS] && (s1_dt_reg != '0);
        col_code = col_low ? POS_LOW : (col_high ? POS_HIGH : POS_MID);
        row_code = row_low ? POS_LOW : (row_high ? POS_HIGH : POS_MID);
        al = abs_gap(s1_dl_reg);
        ar = abs_gap(s1_dr_reg);
        ab = abs_gap(s1_db_reg);
        at = abs_gap(s1_dt_reg);
        s2_region_next = REGION_BITS'(row_code) * REGION_BITS'(3) + REGION_BITS'(col_code);
        s2_cx_next     = (col_code != POS_MID);
        s2_cy_next     = (row_code != POS_MID);
        s2_dx_next     = col_low ? al : ar;
        s2_dy_next     = row_low ? ab : at;
        s2_fx_next     = (ar > al) ? ar : al;
        s2_fy_next     = (at > ab) ? at : ab;
    end

    // Zeroing the square of an inner axis makes the root give the plain gap
    // on the sides and zero inside, so one root serves all nine regions.
    always_comb
    begin
        logic [SQ_BITS-1:0] dx2, dy2;
        dx2         = SQ_BITS'(s2_dx_reg) * SQ_BITS'(s2_dx_reg);
        dy2         = SQ_BITS'(s2_dy_reg) * SQ_BITS'(s2_dy_reg);
        s3_nx2_next = s2_cx_reg ? dx2 : '0;
        s3_ny2_next = s2_cy_reg ? dy2 : '0;
        s3_fx2_next = SQ_BITS'(s2_fx_reg) * SQ_BITS'(s2_fx_reg);
        s3_fy2_next = SQ_BITS'(s2_fy_reg) * SQ_BITS'(s2_fy_reg);
    end

    assign s4_near_next = RAD_BITS'(s3_nx2_reg) + RAD_BITS'(s3_ny2_reg);
    assign s4_far_next  = RAD_BITS'(s3_fx2_reg) + RAD_BITS'(s3_fy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (!hold1) s1_v_reg <= point_valid;
            if (!hold2) s2_v_reg <= s1_v_reg;
            if (!hold3) s3_v_reg <= s2_v_reg;
            if (!hold4) s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold1)
        begin
            s1_dl_reg <= s1_dl_next;
            s1_dr_reg <= s1_dr_next;
            s1_db_reg <= s1_db_next;
            s1_dt_reg <= s1_dt_next;
        end
        if (!hold2)
        begin
            s2_region_reg <= s2_region_next;
            s2_cx_reg     <= s2_cx_next;
            s2_cy_reg     <= s2_cy_next;
            s2_dx_reg     <= s2_dx_next;
            s2_dy_reg     <= s2_dy_next;
            s2_fx_reg     <= s2_fx_next;
            s2_fy_reg     <= s2_fy_next;
        end
        if (!hold3)
        begin
            s3_region_reg <= s2_region_reg;
            s3_nx2_reg    <= s3_nx2_next;
            s3_ny2_reg    <= s3_ny2_next;
            s3_fx2_reg    <= s3_fx2_next;
            s3_fy2_reg    <= s3_fy2_next;
        end
        if (!hold4)
        begin
            s4_region_reg <= s3_region_reg;
            s4_near_reg   <= s4_near_next;
            s4_far_reg    <= s4_far_next;
        end
    end

    assign beat.valid    = s4_v_reg;
    assign beat.region   = s4_region_reg;
    assign beat.near_rad = s4_near_reg;
    assign beat.far_rad  = s4_far_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && hold1 |=> s1_v_reg && $stable(s1_dl_reg) && $stable(s1_dt_reg))
        else $error("held first-stage beat changed");

    a_far_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg |-> (s2_fx_reg >= s2_dx_reg) && (s2_fy_reg >= s2_dy_reg))
        else $error("farthest gap smaller than nearest gap");

    a_rad_order: assert property (@(posedge clk) disable iff (!rst_n)
        s4_v_reg |-> s4_far_reg >= s4_near_reg)
        else $error("near radicand exceeds far radicand");

endmodule

FILE: rtl/pbd_root.sv
// Pipelined integer square root for the near and far radicands, two result
// bits per stage, last stage is the output register. Depends on pbd_pkg.
`timescale 1ns / 1ps

module pbd_root
    import pbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rad_beat_t beat,
    output logic      hold_up,
    output logic      result_valid,
    input  logic      result_stall,
    output result_t   result
);

    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_STAGES      = (DIST_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int REM_BITS        = DIST_BITS + 3;

    typedef struct packed {
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [DIST_BITS-1:0] root;
    } root_acc_t;

    typedef struct packed {
        logic                   valid;
        logic [REGION_BITS-1:0] region;
        root_acc_t              near_acc;
        root_acc_t              far_acc;
    } stage_t;

    // One restoring step: bring down the next pair of radicand bits.
    function automatic root_acc_t root_step(input root_acc_t a);
        root_acc_t           r;
        logic [REM_BITS-1:0] shifted;
        logic [REM_BITS-1:0] trial;
        shifted = {a.rem[REM_BITS-3:0], a.rad[RAD_BITS-1 -: 2]};
        trial   = {1'b0, a.root, 2'b01};
        r.rad   = {a.rad[RAD_BITS-3:0], 2'b00};
        if (shifted >= trial)
        begin
            r.rem  = shifted - trial;
            r.root = {a.root[DIST_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem  = shifted;
            r.root = {a.root[DIST_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    stage_t st_reg  [NUM_STAGES];
    stage_t st_src  [NUM_STAGES];
    stage_t st_next [NUM_STAGES];
    logic   hold    [NUM_STAGES];

    always_comb
    begin
        st_src[0].valid         = beat.valid;
        st_src[0].region        = beat.region;
        st_src[0].near_acc.rad  = beat.near_rad;
        st_src[0].near_acc.rem  = '0;
        st_src[0].near_acc.root = '0;
        st_src[0].far_acc.rad   = beat.far_rad;
        st_src[0].far_acc.rem   = '0;
        st_src[0].far_acc.root  = '0;
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            st_src[s] = st_reg[s-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            st_next[s] = st_src[s];
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (s * STEPS_PER_STAGE + j < DIST_BITS)
                begin
                    st_next[s].near_acc = root_step(st_next[s].near_acc);
                    st_next[s].far_acc  = root_step(st_next[s].far_acc);
                end
            end
        end
    end

    // A stage holds only when it is full and the one after it holds, so
    // bubbles close up behind a stalled result.
    always_comb
    begin
        hold[NUM_STAGES-1] = st_reg[NUM_STAGES-1].valid & result_stall;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            hold[s] = st_reg[s].valid & hold[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                st_reg[s].valid <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                if (!hold[s]) st_reg[s] <= st_next[s];
            end
        end
    end

    assign hold_up          = hold[0];
    assign result_valid     = st_reg[NUM_STAGES-1].valid;
    assign result.region    = st_reg[NUM_STAGES-1].region;
    assign result.near_dist = st_reg[NUM_STAGES-1].near_acc.root;
    assign result.far_dist  = st_reg[NUM_STAGES-1].far_acc.root;

    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.region == REGION_INSIDE |-> result.near_dist == '0)
        else $error("nonzero near distance inside the box");

    a_near_le_far: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.near_dist <= result.far_dist && result.region <= REGION_LAST)
        else $error("near distance above far distance or bad region");

    a_hold_source: assert property (@(posedge clk) disable iff (!rst_n)
        hold_up |-> result_valid && result_stall)
        else $error("pipeline held without a stalled result");

endmodule

FILE: rtl/point_box_distance.sv
// Channel   Direction  Handshake                      Payload
// point     in         point_valid / point_stall      point_t  (point_x, point_y)
// result    out        result_valid / result_stall    result_t (region, near_dist, far_dist)
// config    in         cfg_we                         cfg_index, cfg_data
//
// One point is taken every cycle while point_stall is low; its result passes through
// 4 front-end stages for gaps and squares, then 13 root stages at two bits each.
// Reset clears all valid bits and sets the box registers to zero.
// A stalled result holds the last stage; earlier stages keep filling bubbles,
// and point_stall rises only when every stage up to the input is full.
// Depends on pbd_pkg, pbd_front and pbd_root.
`timescale 1ns / 1ps

module point_box_distance
    import pbd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  point_t                    point,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data
);

    box_t      box_reg;
    rad_beat_t rad_beat;
    logic      root_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BOX_LEFT:   box_reg.box_left   <= cfg_data;
                REG_BOX_BOTTOM: box_reg.box_bottom <= cfg_data;
                REG_BOX_RIGHT:  box_reg.box_right  <= cfg_data;
                REG_BOX_TOP:    box_reg.box_top    <= cfg_data;
                default:        box_reg            <= box_reg;
            endcase
        end
    end

    pbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point       (point),
        .box         (box_reg),
        .hold_in     (root_hold),
        .hold_up     (point_stall),
        .beat        (rad_beat)
    );

    pbd_root u_root (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (rad_beat),
        .hold_up      (root_hold),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: dv/tb_point_box_distance.sv
// Testbench for point_box_distance: streams query points against a series of
// box settings and checks region, nearest and farthest distance of each beat.
// Depends on pbd_pkg and the point_box_distance RTL.
`timescale 1ns / 1ps

module tb_point_box_distance;
    import pbd_pkg::*;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_t;
    typedef enum {BOX_WIDE, BOX_TINY, BOX_EXTREME, BOX_INVERTED} box_kind_t;

    localparam longint COORD_MIN   = -(longint'(1) << (COORD_BITS - 1));
    localparam longint COORD_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam int     HOLD_CYCLES = 300;
    localparam int     STALL_LIMIT = 4000;
    localparam int     TAIL_CYCLES = 40;
    localparam int     PHASE_COUNT = 9;
    localparam int     PHASE_ITEMS = 75;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    point_valid  = 1'b0;
    logic    point_stall;
    point_t  point        = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0]     cfg_data  = '0;

    point_t     pending_points[$];
    result_t    predicted_results[$];
    result_t    oldest_result;
    box_t       box_cfg         = '0;
    idle_mode_t idle_mode       = IDLE_NONE;
    int         hold_count      = 0;
    int         quiet_cycles    = 0;
    int         mismatch_count  = 0;

    idle_mode_t phase_modes[5] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD};
    box_kind_t  phase_boxes[4] = '{BOX_WIDE, BOX_TINY, BOX_EXTREME, BOX_INVERTED};

    point_box_distance dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic longint unsigned abs_gap(longint a, longint b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    // Bitwise integer square root, rounded down.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned rest;
        longint unsigned root;
        longint unsigned probe;
        rest  = v;
        root  = 0;
        probe = longint'(1) << 62;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic result_t box_distance(point_t p, box_t b);
        longint            x;
        longint            y;
        logic [1:0]        col;
        logic [1:0]        row;
        longint unsigned   dx;
        longint unsigned   dy;
        longint unsigned   fx;
        longint unsigned   fy;
        longint unsigned   near_val;
        longint unsigned   far_val;
        result_t           r;
        x   = $signed(p.point_x);
        y   = $signed(p.point_y);
        // An inverted box still resolves: the low side is tested first.
        col = POS_MID;
        if (x < b.box_left)
            col = POS_LOW;
        else if (x > b.box_right)
            col = POS_HIGH;
        row = POS_MID;
        if (y < b.box_bottom)
            row = POS_LOW;
        else if (y > b.box_top)
            row = POS_HIGH;
        dx = (col == POS_LOW) ? abs_gap(x, b.box_left) : abs_gap(x, b.box_right);
        dy = (row == POS_LOW) ? abs_gap(y, b.box_bottom) : abs_gap(y, b.box_top);
        if (col != POS_MID && row != POS_MID)
            near_val = floor_sqrt(dx * dx + dy * dy);
        else if (col != POS_MID)
            near_val = dx;
        else if (row != POS_MID)
            near_val = dy;
        else
            near_val = 0;
        fx = abs_gap(x, b.box_left);
        if (abs_gap(x, b.box_right) > fx)
            fx = abs_gap(x, b.box_right);
        fy = abs_gap(y, b.box_bottom);
        if (abs_gap(y, b.box_top) > fy)
            fy = abs_gap(y, b.box_top);
        far_val     = floor_sqrt(fx * fx + fy * fy);
        r.region    = REGION_BITS'(3 * row + col);
        r.near_dist = near_val[DIST_BITS-1:0];
        r.far_dist  = far_val[DIST_BITS-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic point_t make_point(longint x, longint y);
        point_t p;
        p.point_x = x[COORD_BITS-1:0];
        p.point_y = y[COORD_BITS-1:0];
        return p;
    endfunction

    function automatic box_t make_box(longint l, longint b, longint r, longint t);
        box_t bx;
        bx.box_left   = l[COORD_BITS-1:0];
        bx.box_bottom = b[COORD_BITS-1:0];
        bx.box_right  = r[COORD_BITS-1:0];
        bx.box_top    = t[COORD_BITS-1:0];
        return bx;
    endfunction

    function automatic longint random_coord();
        logic signed [COORD_BITS-1:0] v;
        v = COORD_BITS'($urandom());
        return v;
    endfunction

    // Either a full-range value, a value close to one edge or a value between them.
    function automatic longint pick_coord(longint lo, longint hi);
        longint base;
        base = (lo <= hi) ? lo : hi;
        case ($urandom_range(3))
            0: return random_coord();
            1: return lo + longint'($urandom_range(16)) - 8;
            2: return hi + longint'($urandom_range(16)) - 8;
            default: return base + longint'($urandom_range(int'(abs_gap(lo, hi))));
        endcase
    endfunction

    function automatic box_t random_box(box_kind_t kind);
        longint a;
        longint b;
        longint c;
        longint d;
        longint swap;
        a = random_coord();
        b = random_coord();
        c = random_coord();
        d = random_coord();
        if (a > b)
        begin
            swap = a;
            a    = b;
            b    = swap;
        end
        if (c > d)
        begin
            swap = c;
            c    = d;
            d    = swap;
        end
        case (kind)
            BOX_WIDE:     return make_box(a, c, b, d);
            BOX_TINY:
            begin
                a = longint'($urandom_range((1 << COORD_BITS) - 100)) + COORD_MIN;
                c = longint'($urandom_range((1 << COORD_BITS) - 100)) + COORD_MIN;
                return make_box(a, c, a + $urandom_range(64), c + $urandom_range(64));
            end
            BOX_EXTREME:
            begin
                if ($urandom_range(1) == 0)
                    return make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
                return make_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
            end
            default:      return make_box(b, d, a, c);
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t index, logic [COORD_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
    endtask

    // Only called with the block empty, so the local copy can change at once.
    task automatic write_box(box_t b);
        write_reg(REG_BOX_LEFT, b.box_left);
        write_reg(REG_BOX_BOTTOM, b.box_bottom);
        write_reg(REG_BOX_RIGHT, b.box_right);
        write_reg(REG_BOX_TOP, b.box_top);
        @(posedge clk);
        cfg_we  <= 1'b0;
        box_cfg = b;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_points.size() != 0 || point_valid || predicted_results.size() != 0);
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int send_idle_pct(idle_mode_t m);
        return (m == IDLE_SEND) ? 76 : (m == IDLE_BOTH) ? 32 : 0;
    endfunction

    function automatic int recv_stall_pct(idle_mode_t m);
        return (m == IDLE_RECV) ? 76 : (m == IDLE_BOTH) ? 32 : 0;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
        end
        else if (!point_valid || !point_stall)
        begin
            if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct(idle_mode))
            begin
                point       <= pending_points.pop_front();
                point_valid <= 1'b1;
            end
            else
            begin
                point_valid <= 1'b0;
            end
        end
    end

    // Receiver: in the hold phase it refuses results for a long stretch first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_count   <= 0;
        end
        else if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES)
        begin
            hold_count   <= hold_count + 1;
            result_stall <= 1'b1;
        end
        else
        begin
            if (idle_mode != IDLE_HOLD)
                hold_count <= 0;
            result_stall <= ($urandom_range(99) < recv_stall_pct(idle_mode));
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_valid && !point_stall)
                predicted_results.push_back(box_distance(point, box_cfg));
            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat, region %0d", result.region));
                end
                else
                begin
                    oldest_result = predicted_results.pop_front();
                    if (result.region !== oldest_result.region)
                        report_mismatch($sformatf("region %0d, predicted %0d",
                                                  result.region, oldest_result.region));
                    if (result.near_dist !== oldest_result.near_dist)
                        report_mismatch($sformatf("near_dist %0d, predicted %0d",
                                                  result.near_dist, oldest_result.near_dist));
                    if (result.far_dist !== oldest_result.far_dist)
                        report_mismatch($sformatf("far_dist %0d, predicted %0d",
                                                  result.far_dist, oldest_result.far_dist));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((point_valid && !point_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // All nine regions, points on the edges, and the coordinate extremes.
        write_box(make_box(-100, -50, 200, 300));
        pending_points.push_back(make_point(-150, -90));
        pending_points.push_back(make_point(50, -90));
        pending_points.push_back(make_point(260, -90));
        pending_points.push_back(make_point(-150, 100));
        pending_points.push_back(make_point(50, 100));
        pending_points.push_back(make_point(260, 100));
        pending_points.push_back(make_point(-150, 350));
        pending_points.push_back(make_point(50, 350));
        pending_points.push_back(make_point(260, 350));
        pending_points.push_back(make_point(-100, -50));
        pending_points.push_back(make_point(200, 300));
        pending_points.push_back(make_point(-101, 301));
        pending_points.push_back(make_point(COORD_MIN, COORD_MIN));
        pending_points.push_back(make_point(COORD_MAX, COORD_MAX));
        pending_points.push_back(make_point(COORD_MIN, COORD_MAX));
        pending_points.push_back(make_point(COORD_MAX, COORD_MIN));
        wait_drained();

        // Box spanning the whole range gives the largest farthest distance.
        write_box(make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        pending_points.push_back(make_point(COORD_MIN, COORD_MIN));
        pending_points.push_back(make_point(COORD_MAX, COORD_MAX));
        pending_points.push_back(make_point(0, 0));
        wait_drained();

        // Inverted box: min above max on both axes.
        write_box(make_box(100, 50, -100, -50));
        pending_points.push_back(make_point(0, 0));
        pending_points.push_back(make_point(150, 80));
        pending_points.push_back(make_point(-150, -80));
        pending_points.push_back(make_point(100, -50));
        wait_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_box(random_box(phase_boxes[ph % 4]));
            idle_mode = phase_modes[ph % 5];
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_points.push_back(make_point(pick_coord(box_cfg.box_left, box_cfg.box_right),
                                                    pick_coord(box_cfg.box_bottom, box_cfg.box_top)));
            wait_drained();
            idle_mode = IDLE_NONE;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pbd_pkg.sv
rtl/pbd_front.sv
rtl/pbd_root.sv
rtl/point_box_distance.sv
dv/tb_point_box_distance.sv
